>>> design/fppd_pkg.sv
// Package for the frame peak/power detector: fixed field widths, register
// indexes and reset values shared by every module of the block.
// No dependencies.
`default_nettype none

package fppd_pkg;

    localparam int SAMPLE_W   = 16;  // signed Q1.15 sample
    localparam int SQ_W       = 31;  // square of a sample, at most 2^30
    localparam int PLIM_W     = 13;  // peak_limit register
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_THRESHOLD  = 1'b0,
        REG_PEAK_LIMIT = 1'b1
    } cfg_reg_t;

    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST  = '0;
    localparam logic [PLIM_W-1:0]          PEAK_LIMIT_RST = 13'd5;

endpackage

`default_nettype wire

>>> design/fppd_in_stage.sv
// Input register of the detector: captures one sample request and squares it.
// Depends on fppd_pkg.
`default_nettype none

module fppd_in_stage
    import fppd_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [IN_TDATA_W-1:0]      s_tdata,   // [15:0] sample
    input  wire logic                       s_tlast,
    input  wire logic                       item_take,
    output logic                            item_valid,
    output logic signed [SAMPLE_W-1:0]      item_sample,
    output logic                            item_last,
    output logic [SQ_W-1:0]                 item_sq
);

    logic                         valid_reg, valid_next;
    logic signed [SAMPLE_W-1:0]   sample_reg;
    logic                         last_reg;
    logic [SQ_W-1:0]              sq_reg;
    logic signed [SAMPLE_W-1:0]   in_sample;
    logic signed [2*SAMPLE_W-1:0] in_prod;
    logic                         accept;

    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign in_prod   = in_sample * in_sample;
    assign s_tready  = !valid_reg || item_take;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // The square never exceeds 2^30, so the top bit of the product is dropped.
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= in_sample;
            last_reg   <= s_tlast;
            sq_reg     <= in_prod[SQ_W-1:0];
        end
    end

    assign item_valid  = valid_reg;
    assign item_sample = sample_reg;
    assign item_last   = last_reg;
    assign item_sq     = sq_reg;

endmodule

`default_nettype wire

>>> design/fppd_frame_acc.sv
// Per-frame accumulator: neighbour samples, peak count, sample count and sum
// of squares, with a result register loaded on the last sample of a frame.
// Depends on fppd_pkg.
`default_nettype none

module fppd_frame_acc
    import fppd_pkg::*;
#(
    parameter int MAX_FRAME = 4096,
    parameter int CNT_W     = 13,
    parameter int SUM_W     = 43
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       item_valid,
    input  wire logic signed [SAMPLE_W-1:0] item_sample,
    input  wire logic                       item_last,
    input  wire logic [SQ_W-1:0]            item_sq,
    output logic                            item_take,
    input  wire logic signed [SAMPLE_W-1:0] threshold,
    input  wire logic                       res_ready,
    output logic                            res_valid,
    output logic [SUM_W-1:0]                res_sum,
    output logic [CNT_W-1:0]                res_count,
    output logic [CNT_W-1:0]                res_peaks,
    output logic                            res_ovf
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic signed [SAMPLE_W-1:0] older_reg, older_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           peaks_reg, peaks_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic                       ovf_reg, ovf_next;
    logic                       res_valid_reg, res_valid_next;
    logic [SUM_W-1:0]           res_sum_reg;
    logic [CNT_W-1:0]           res_count_reg;
    logic [CNT_W-1:0]           res_peaks_reg;
    logic                       res_ovf_reg;

    logic                       kept;
    logic                       is_peak;
    logic                       res_free;

    assign res_free  = !res_valid_reg || res_ready;
    assign item_take = item_valid && (!item_last || res_free);

    assign kept    = count_reg < CNT_MAX;
    // The held sample is a peak only once both of its neighbours are known.
    assign is_peak = (count_reg >= CNT_TWO) && (prev_reg > threshold) &&
                     (prev_reg > older_reg) && (prev_reg > item_sample);

    // Updated frame values, as if the current sample had been taken in.
    always_comb begin
        prev_next  = prev_reg;
        older_next = older_reg;
        count_next = count_reg;
        peaks_next = peaks_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        if (kept) begin
            if (is_peak && (peaks_reg < CNT_MAX)) begin
                peaks_next = peaks_reg + CNT_W'(1);
            end
            sum_next   = sum_reg + SUM_W'(item_sq);
            count_next = count_reg + CNT_W'(1);
            older_next = prev_reg;
            prev_next  = item_sample;
        end else begin
            ovf_next = 1'b1;
        end
    end

    always_comb begin
        if (item_take && item_last) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '0;
            older_reg     <= '0;
            count_reg     <= '0;
            peaks_reg     <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (item_take) begin
                if (item_last) begin
                    prev_reg  <= '0;
                    older_reg <= '0;
                    count_reg <= '0;
                    peaks_reg <= '0;
                    sum_reg   <= '0;
                    ovf_reg   <= 1'b0;
                end else begin
                    prev_reg  <= prev_next;
                    older_reg <= older_next;
                    count_reg <= count_next;
                    peaks_reg <= peaks_next;
                    sum_reg   <= sum_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && item_last) begin
            res_sum_reg   <= sum_next;
            res_count_reg <= count_next;
            res_peaks_reg <= peaks_next;
            res_ovf_reg   <= ovf_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_sum   = res_sum_reg;
    assign res_count = res_count_reg;
    assign res_peaks = res_peaks_reg;
    assign res_ovf   = res_ovf_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("Sample count ran past the frame limit.");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && item_last) |=> (count_reg == '0 && !ovf_reg && sum_reg == '0))
        else $error("Frame state not cleared after the last sample.");

    a_ovf_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (count_reg == CNT_MAX))
        else $error("Overflow flagged before the frame was full.");

    a_peaks_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        peaks_reg <= count_reg)
        else $error("More peaks than samples in the frame.");
`endif

endmodule

`default_nettype wire

>>> design/fppd_decide.sv
// Decision stages: power bound multiply, then the compares into the output
// register of the result channel. Depends on fppd_pkg.
`default_nettype none

module fppd_decide
    import fppd_pkg::*;
#(
    parameter int CNT_W = 13,
    parameter int SUM_W = 43
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic signed [SAMPLE_W-1:0] threshold,
    input  wire logic [PLIM_W-1:0]          peak_limit,
    input  wire logic                       res_valid,
    output logic                            res_ready,
    input  wire logic [SUM_W-1:0]           res_sum,
    input  wire logic [CNT_W-1:0]           res_count,
    input  wire logic [CNT_W-1:0]           res_peaks,
    input  wire logic                       res_ovf,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [OUT_TDATA_W-1:0]          m_tdata   // [0] detected, [1] frame_too_long
);

    localparam int CMP_W = (CNT_W > PLIM_W) ? CNT_W : PLIM_W;

    logic signed [2*SAMPLE_W-1:0] tsq_prod;
    logic [SQ_W-1:0]              tsq_reg;
    logic [SUM_W-1:0]             bound;

    logic                         mul_valid_reg, mul_valid_next;
    logic [SUM_W-1:0]             bound_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic                         peak_ok_reg;
    logic                         ovf_reg;

    logic                         out_valid_reg, out_valid_next;
    logic                         detected_reg;
    logic                         too_long_reg;
    logic                         out_free;

    assign tsq_prod = threshold * threshold;
    // Product fits in SUM_W bits since the count never exceeds the frame limit.
    assign bound    = SUM_W'(tsq_reg) * SUM_W'(res_count);

    assign out_free  = !out_valid_reg || m_tready;
    assign res_ready = !mul_valid_reg || out_free;

    always_comb begin
        if (res_valid && res_ready) begin
            mul_valid_next = 1'b1;
        end else if (out_free) begin
            mul_valid_next = 1'b0;
        end else begin
            mul_valid_next = mul_valid_reg;
        end
    end

    always_comb begin
        if (mul_valid_reg && out_free) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The threshold square is registered from the threshold register; it is
    // settled long before a frame result reaches the multiplier.
    always_ff @(posedge aclk) begin
        tsq_reg <= tsq_prod[SQ_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            bound_reg   <= bound;
            sum_reg     <= res_sum;
            peak_ok_reg <= CMP_W'(res_peaks) > CMP_W'(peak_limit);
            ovf_reg     <= res_ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_valid_reg && out_free) begin
            detected_reg <= (sum_reg > bound_reg) && peak_ok_reg;
            too_long_reg <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-2){1'b0}}, too_long_reg, detected_reg};

`ifndef SYNTHESIS
    a_out_from_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(mul_valid_reg))
        else $error("Result request raised without a decision in flight.");

    a_out_stable_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("Result request changed while the receiver stalled.");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_valid_reg && !out_free) |=> mul_valid_reg)
        else $error("Decision stage dropped a result while the output stalled.");
`endif

endmodule

`default_nettype wire

>>> design/frame_peak_power_detector.sv
// Frame peak/power detector, top level: configuration registers and the
// three pipeline parts. Depends on fppd_pkg, fppd_in_stage, fppd_frame_acc
// and fppd_decide.
//
// Usage: samples (signed Q1.15) enter on the s_ channel one request per
// clock unless stalled, framed by s_tlast. Each frame yields exactly one
// result request on the m_ channel: detected when the sum of squares exceeds
// threshold^2 times the frame length and the strict local maxima above
// threshold outnumber peak_limit; frame_too_long when more than MAX_FRAME
// samples arrived (only the first MAX_FRAME count). Non-last samples give
// no result. Throughput: one sample per cycle unless s_tready is low.
// After the last sample of a frame is accepted, its result passes the input
// register, accumulator, bound multiply and output register in turn.
// A stalled m_ channel holds its result while non-last samples keep flowing;
// s_tready falls only when a further frame end finds all result stages full.
// Reset (aresetn low, synchronous) empties the pipeline, clears the frame
// state and sets threshold to 0 and peak_limit to 5. Configuration writes
// land in registers and belong between frames or at idle times.
`default_nettype none

module frame_peak_power_detector
    import fppd_pkg::*;
#(
    parameter int MAX_FRAME = 4096
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [IN_TDATA_W-1:0]   s_tdata,   // [15:0] sample
    input  wire logic                    s_tlast,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]       m_tdata    // [0] detected, [1] frame_too_long
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int SUM_W = (SQ_W - 1) + CNT_W;

    logic signed [SAMPLE_W-1:0] threshold_reg;
    logic [PLIM_W-1:0]          peak_limit_reg;

    logic                       item_valid;
    logic signed [SAMPLE_W-1:0] item_sample;
    logic                       item_last;
    logic [SQ_W-1:0]            item_sq;
    logic                       item_take;

    logic                       res_valid;
    logic                       res_ready;
    logic [SUM_W-1:0]           res_sum;
    logic [CNT_W-1:0]           res_count;
    logic [CNT_W-1:0]           res_peaks;
    logic                       res_ovf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= THRESHOLD_RST;
            peak_limit_reg <= PEAK_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_THRESHOLD:  threshold_reg  <= cfg_wdata[SAMPLE_W-1:0];
                REG_PEAK_LIMIT: peak_limit_reg <= cfg_wdata[PLIM_W-1:0];
                default: ;
            endcase
        end
    end

    fppd_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .item_take   (item_take),
        .item_valid  (item_valid),
        .item_sample (item_sample),
        .item_last   (item_last),
        .item_sq     (item_sq)
    );

    fppd_frame_acc #(
        .MAX_FRAME (MAX_FRAME),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W)
    ) u_frame_acc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (item_valid),
        .item_sample (item_sample),
        .item_last   (item_last),
        .item_sq     (item_sq),
        .item_take   (item_take),
        .threshold   (threshold_reg),
        .res_ready   (res_ready),
        .res_valid   (res_valid),
        .res_sum     (res_sum),
        .res_count   (res_count),
        .res_peaks   (res_peaks),
        .res_ovf     (res_ovf)
    );

    fppd_decide #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_decide (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .threshold  (threshold_reg),
        .peak_limit (peak_limit_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_sum    (res_sum),
        .res_count  (res_count),
        .res_peaks  (res_peaks),
        .res_ovf    (res_ovf),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

>>> verif/fppd_checker.sv
`timescale 1ns / 1ps
// Checker for the frame peak/power detector: follows register writes and
// accepted sample requests, predicts one verdict per frame and compares it with
// each result request. Depends on fppd_pkg.
module fppd_checker
    import fppd_pkg::*;
#(
    parameter int MAX_FRAME = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     outstanding,
    output int                     mismatches
);

    typedef struct packed {
        logic detected;
        logic too_long;
    } verdict_t;

    verdict_t verdict_q[$];

    logic signed [SAMPLE_W-1:0] thr_reg;
    logic [PLIM_W-1:0]          plim_reg;
    logic signed [SAMPLE_W-1:0] prev_smp;
    logic signed [SAMPLE_W-1:0] older_smp;
    int                         kept;
    int                         peaks;
    longint                     power_acc;
    bit                         overflow;

    task automatic clear_frame();
        prev_smp  = '0;
        older_smp = '0;
        kept      = 0;
        peaks     = 0;
        power_acc = 0;
        overflow  = 1'b0;
    endtask

    // Advances the frame state by one sample; a frame end queues its verdict.
    task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] smp, input bit lst);
        longint   bound;
        verdict_t v;
        if (kept >= MAX_FRAME) begin
            overflow = 1'b1;
        end else begin
            // The previous sample is judged now that its right-hand neighbour is known.
            if (kept >= 2 && prev_smp > thr_reg && prev_smp > older_smp && prev_smp > smp &&
                peaks < MAX_FRAME)
                peaks++;
            power_acc += longint'(smp) * longint'(smp);
            kept++;
            older_smp = prev_smp;
            prev_smp  = smp;
        end
        if (lst) begin
            bound = longint'(thr_reg) * longint'(thr_reg) * longint'(kept);
            v.detected = (power_acc > bound) && (peaks > int'(plim_reg));
            v.too_long = overflow;
            verdict_q.push_back(v);
            clear_frame();
        end
    endtask

    initial begin
        outstanding = 0;
        mismatches  = 0;
        thr_reg     = THRESHOLD_RST;
        plim_reg    = PEAK_LIMIT_RST;
        clear_frame();
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            thr_reg  = THRESHOLD_RST;
            plim_reg = PEAK_LIMIT_RST;
            clear_frame();
            verdict_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_THRESHOLD:  thr_reg = cfg_wdata[SAMPLE_W-1:0];
                    REG_PEAK_LIMIT: plim_reg = cfg_wdata[PLIM_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result request with none expected, got detected=%b too_long=%b",
                                 $realtime, m_tdata[0], m_tdata[1]);
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.detected || m_tdata[1] !== want.too_long) begin
                        if (mismatches < 10)
                            $display("%0t: verdict mismatch, expected detected=%b too_long=%b, got detected=%b too_long=%b",
                                     $realtime, want.detected, want.too_long,
                                     m_tdata[0], m_tdata[1]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                absorb_sample(s_tdata[SAMPLE_W-1:0], s_tlast);
        end
        outstanding = verdict_q.size();
    end

endmodule

>>> verif/tb_frame_peak_power_detector.sv
`timescale 1ns / 1ps
// Top of the frame peak/power detector testbench: clock, reset, sample and
// register stimulus, result back-pressure and the verdict.
// Depends on fppd_pkg, frame_peak_power_detector and fppd_checker.
module tb_frame_peak_power_detector;
    import fppd_pkg::*;

    localparam int MAX_FRAME   = 4096;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 130;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // [15:0] sample
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [0] detected, [1] frame_too_long

    int outstanding;
    int mismatches;
    int cycle_cnt;
    bit quiet;
    bit stall_request;

    always #5 aclk = ~aclk;

    frame_peak_power_detector #(
        .MAX_FRAME(MAX_FRAME)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    fppd_checker #(
        .MAX_FRAME(MAX_FRAME)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // Offers one sample request, starting and ending on a falling edge.
    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input bit lst);
        if (!quiet && $urandom_range(0, 99) < 8) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = smp;
        s_tlast  = lst;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Shaped frames alternate high and low samples so that peaks are common.
    task automatic send_frame(input int len, input bit shaped);
        logic [SAMPLE_W-1:0] smp;
        for (int i = 0; i < len; i++) begin
            if (shaped && $urandom_range(0, 9) != 0)
                smp = (i % 2) ? 16'($urandom_range(16384, 32767))
                              : 16'(-int'($urandom_range(0, 16384)));
            else
                smp = 16'($urandom_range(0, 65535));
            push_sample(smp, i == len - 1);
        end
    endtask

    // Waits until every queued verdict has been matched by a result, then pauses.
    task automatic settle();
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request) begin
                m_tready = 1'b0;
                repeat (300) @(negedge aclk);
                stall_request = 1'b0;
            end else begin
                m_tready = quiet || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int len;
        int phase_items;
        logic [CFG_DATA_W-1:0] thr_val;
        logic [CFG_DATA_W-1:0] plim_val;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = REG_THRESHOLD;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        quiet         = 1'b0;
        stall_request = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset settings: single-sample frames at both sample extremes.
        push_sample(16'sd32767, 1'b1);
        push_sample(-16'sd32768, 1'b1);

        settle();
        write_reg(REG_THRESHOLD, 16'd100);
        write_reg(REG_PEAK_LIMIT, 16'd0);
        push_sample(16'd0, 1'b0);   // clean peak in the middle
        push_sample(16'd200, 1'b0);
        push_sample(16'd0, 1'b1);
        push_sample(16'd0, 1'b0);   // flat top, equal neighbours
        push_sample(16'd200, 1'b0);
        push_sample(16'd200, 1'b0);
        push_sample(16'd0, 1'b1);
        push_sample(16'd0, 1'b0);   // candidate exactly at threshold
        push_sample(16'd100, 1'b0);
        push_sample(16'd0, 1'b1);
        push_sample(16'd0, 1'b0);   // highest sample is the final one
        push_sample(16'd300, 1'b1);

        settle();
        write_reg(REG_THRESHOLD, 16'h8000);
        write_reg(REG_PEAK_LIMIT, 16'd4096);
        push_sample(-16'sd32768, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(-16'sd32768, 1'b1);

        settle();
        write_reg(REG_THRESHOLD, 16'h7FFF);
        write_reg(REG_PEAK_LIMIT, 16'd0);
        push_sample(16'sd32767, 1'b0);
        push_sample(-16'sd32768, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: thr_val = 16'd0;
                1: thr_val = 16'h8000;
                2: thr_val = 16'h7FFF;
                7: thr_val = 16'($urandom_range(0, 65535));
                default: thr_val = 16'(int'($urandom_range(0, 24000)) - 12000);
            endcase
            case (p)
                0: plim_val = 16'd0;
                1: plim_val = 16'd4096;
                2: plim_val = 16'd5;
                default: plim_val = 16'($urandom_range(0, 8));
            endcase
            write_reg(REG_THRESHOLD, thr_val);
            write_reg(REG_PEAK_LIMIT, plim_val);
            quiet = (p == 2);
            // Short frames under a long receiver hold-off fill the result stages.
            if (p == 4)
                stall_request = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if (p == 4)
                    len = $urandom_range(1, 3);
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(25, 200);
                else
                    len = $urandom_range(1, 24);
                send_frame(len, $urandom_range(0, 9) < 7);
                phase_items += len;
            end
            quiet = 1'b0;
        end

        // A last short frame under fresh settings.
        settle();
        write_reg(REG_THRESHOLD, 16'(int'($urandom_range(0, 8000)) - 4000));
        write_reg(REG_PEAK_LIMIT, 16'($urandom_range(0, 3000)));
        send_frame(5, 1'b1);

        settle();
        repeat (10) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
design/fppd_pkg.sv
design/fppd_in_stage.sv
design/fppd_frame_acc.sv
design/fppd_decide.sv
design/frame_peak_power_detector.sv
verif/fppd_checker.sv
verif/tb_frame_peak_power_detector.sv
